[hdl/cdq_pkg.sv]
// shared types, codes and defaults for the circular deque with id search
package cdq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] record_id;
	} cdq_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [4:0] occupancy;
	} cdq_rsp_t;

	typedef struct packed {
		logic load;
		logic commit;
		logic scan_start;
		logic scan_run;
		logic post_search;
	} cdq_cmd_t;

	typedef struct packed {
		logic search_go;
		logic out_free;
		logic scan_end;
	} cdq_stat_t;

endpackage

[hdl/cdq_ctrl.sv]
// sequencer for the deque: accept, execute, scan, finish
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output cdq_pkg::cdq_cmd_t cmd,
	input  cdq_pkg::cdq_stat_t stat
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.search_go) begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end else if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_end) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.post_search = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[hdl/cdq_dpath.sv]
// deque datapath: pointers, count, id store, scan compare and result register
module cdq_dpath #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cdq_pkg::cdq_req_t  req,
	output cdq_pkg::cdq_rsp_t  rsp,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  cdq_pkg::cdq_cmd_t  cmd,
	output cdq_pkg::cdq_stat_t stat
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

	logic [31:0]        mem [DEPTH];
	cdq_pkg::cdq_req_t  req_q;
	logic [IDX_W-1:0]   front_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   scan_slot_q;
	logic [CNT_W-1:0]   scan_left_q;
	logic [31:0]        rd_data_s1;
	logic               rd_vld_s1;
	logic               hit_q;
	cdq_pkg::cdq_rsp_t  rsp_q;
	logic               rsp_valid_q;

	logic [IDX_W-1:0]   front_dec;
	logic [IDX_W-1:0]   front_inc;
	logic [IDX_W-1:0]   scan_inc;
	logic [SUM_W-1:0]   back_sum;
	logic [IDX_W-1:0]   back_slot;
	logic               full;
	logic               empty;
	logic               match;
	logic               rd_en;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [IDX_W-1:0]   front_nxt;
	logic [CNT_W-1:0]   count_nxt;
	logic [1:0]         status_nxt;

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign scan_inc  = (scan_slot_q == LAST_SLOT) ? '0 : scan_slot_q + 1'b1;

	// slot after the back entry, one conditional subtract for the wrap
	always_comb begin
		back_sum  = {1'b0, front_q} + SUM_W'(count_q);
		back_slot = (back_sum >= DEPTH_SUM) ? IDX_W'(back_sum - DEPTH_SUM)
			: back_sum[IDX_W-1:0];
	end

	// decode of a non-search operation
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = back_slot;
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = cdq_pkg::ST_DONE;
		unique case (req_q.opcode)
			cdq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_nxt = cdq_pkg::ST_OVERFLOW;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_nxt = cdq_pkg::ST_OVERFLOW;
				end else begin
					mem_we    = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_nxt = cdq_pkg::ST_UNDERFLOW;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			cdq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status_nxt = cdq_pkg::ST_UNDERFLOW;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = cdq_pkg::ST_DONE;
			end
		endcase
	end

	assign match = rd_vld_s1 && (rd_data_s1 == $unsigned(req_q.record_id));
	assign rd_en = cmd.scan_run && (scan_left_q != '0) && !match;

	assign stat.search_go = (req_q.opcode == cdq_pkg::OP_SEARCH) && !empty;
	assign stat.out_free  = !rsp_valid_q || rsp_ready;
	assign stat.scan_end  = match || ((scan_left_q == '0) && !rd_vld_s1);

	// id store
	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			mem[mem_waddr] <= $unsigned(req_q.record_id);
		end
		if (rd_en) begin
			rd_data_s1 <= mem[scan_slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.scan_start) begin
			scan_slot_q <= front_q;
			scan_left_q <= count_q;
		end else if (rd_en) begin
			scan_slot_q <= scan_inc;
			scan_left_q <= scan_left_q - 1'b1;
		end
		if (cmd.commit) begin
			rsp_q.status    <= status_nxt;
			rsp_q.found     <= 1'b0;
			rsp_q.occupancy <= 5'(count_nxt);
		end else if (cmd.post_search) begin
			rsp_q.status    <= cdq_pkg::ST_DONE;
			rsp_q.found     <= hit_q;
			rsp_q.occupancy <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end
			if (cmd.scan_start) begin
				rd_vld_s1 <= 1'b0;
				hit_q     <= 1'b0;
			end else if (cmd.scan_run) begin
				rd_vld_s1 <= rd_en;
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit || cmd.post_search) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

[hdl/circular_deque_with_id_search.sv]
// top level of the circular deque of record ids with id search
// push, pop, unused opcodes, empty search: result registered in S_EXEC once the result register is free
// search: ids compared from the front in S_SCAN until a hit or past the last entry, result registered
// in S_FINISH once the result register is free; the sequencer then returns to idle for the next accept
// a waiting result that is not taken holds the finish of the next transaction until it leaves
// arst_n clears pointers, count and result valid at once; ids stay undefined; ready at release
module circular_deque_with_id_search #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cdq_pkg::cdq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cdq_pkg::cdq_rsp_t rsp
);

	// command and status between sequencer and datapath
	cdq_pkg::cdq_cmd_t  cmd;
	cdq_pkg::cdq_stat_t stat;

	// sequencer: takes one transaction, runs it, waits for a free result slot
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: front pointer, count, id store, one compare per cycle on search,
	// result register so the next transaction can start while a result waits
	cdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
